@@ rtl/core/tma_pkg.sv @@
// Package: sizes, ALU operation codes and shared structs of the trimmed moving average core.
`default_nettype none
package tma_pkg;

  // Sample width and window size (window length is a power of two).
  localparam int SAMPLE_W   = 12;
  localparam int WINDOW_LOG2 = 4;
  localparam int WINDOW     = 1 << WINDOW_LOG2;
  localparam int IDX_W      = (WINDOW_LOG2 > 0) ? WINDOW_LOG2 : 1;
  localparam int SUM_W      = SAMPLE_W + WINDOW_LOG2;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};
  localparam logic [IDX_W-1:0]    IDX_LAST   = IDX_W'(WINDOW - 1);

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_EXT  = 2'd1,
    OP_ADD  = 2'd2,
    OP_SUB  = 2'd3
  } alu_op_t;

  typedef struct packed {
    alu_op_t             op;
    logic [SAMPLE_W-1:0] operand;
    logic [SUM_W-1:0]    acc;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] lo;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0]    acc;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] lo;
  } alu_res_t;

endpackage
`default_nettype wire

@@ rtl/core/tma_in_if.sv @@
// Interface: input sample channel with valid/ready handshake.
`default_nettype none
interface tma_in_if;
  logic                          valid;
  logic                          ready;
  logic [tma_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tma_out_if.sv @@
// Interface: filtered result channel with valid/ready handshake.
`default_nettype none
interface tma_out_if;
  logic                          valid;
  logic                          ready;
  logic [tma_pkg::SAMPLE_W-1:0]  filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tma_window.sv @@
// Sample window: shift line of the last WINDOW samples with one indexed read port.
`default_nettype none
module tma_window (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         shift_en,
  input  wire logic [tma_pkg::SAMPLE_W-1:0] sample_in,
  input  wire logic [tma_pkg::IDX_W-1:0]    rd_idx,
  output logic      [tma_pkg::SAMPLE_W-1:0] rd_data
);
  import tma_pkg::*;

  logic [SAMPLE_W-1:0] taps_r [WINDOW];

  // Shift toward the old end, insert the newest sample at entry 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) taps_r[i] <= '0;
    end else if (shift_en) begin
      taps_r[0] <= sample_in;
      for (int i = 1; i < WINDOW; i++) taps_r[i] <= taps_r[i-1];
    end
  end

  // Select the entry the sequencer is visiting
  assign rd_data = taps_r[rd_idx];

endmodule
`default_nettype wire

@@ rtl/core/tma_alu.sv @@
// Shared arithmetic unit: extreme tracking, accumulate and subtract.
`default_nettype none
module tma_alu (
  input  wire tma_pkg::alu_req_t req,
  output tma_pkg::alu_res_t      res
);
  import tma_pkg::*;

  logic [SUM_W-1:0] operand_ext;

  assign operand_ext = SUM_W'(req.operand);

  always_comb begin
    res = '{acc: req.acc, hi: req.hi, lo: req.lo};
    case (req.op)
      OP_EXT: begin
        // Track the running maximum and minimum
        if (req.operand > req.hi) res.hi = req.operand;
        if (req.operand < req.lo) res.lo = req.operand;
      end
      OP_ADD:  res.acc = req.acc + operand_ext;
      OP_SUB:  res.acc = req.acc - operand_ext;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/trimmed_moving_average_core.sv @@
// Top level: trimmed moving average core with its sequencer and result register.
//
// Each accepted sample is shifted into a 16-entry window (zeros after reset), and the
// result is the window sum minus one maximum and one minimum, divided by the window
// length with truncation. From acceptance to a loaded result an item takes these steps:
// acceptance, one pass over the window to find the extremes, a second pass to
// accumulate the sum, the subtraction of the maximum and then of the minimum, and the
// load of the output register (it waits while an untaken result is still there); all
// of it runs through a single shared arithmetic unit stepped by the window index.
// in_ch.ready is high only while the sequencer is idle; a finished result waits in
// the output register without holding off the next sample.
`default_nettype none
module trimmed_moving_average_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tma_in_if.sink     in_ch,
  tma_out_if.source  out_ch
);
  import tma_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXT   = 6'b000010,
    S_SUM   = 6'b000100,
    S_SUBHI = 6'b001000,
    S_SUBLO = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [SUM_W-1:0]    acc_r, acc_nxt;
  logic [SAMPLE_W-1:0] hi_r, hi_nxt;
  logic [SAMPLE_W-1:0] lo_r, lo_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_data_r, out_data_nxt;

  logic                in_take;
  logic                out_load;
  logic [SAMPLE_W-1:0] win_data;
  alu_req_t            alu_req;
  alu_res_t            alu_res;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  tma_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (in_take),
    .sample_in (in_ch.sample),
    .rd_idx    (idx_r),
    .rd_data   (win_data)
  );

  // Pick the operation for the shared unit
  always_comb begin
    alu_req = '{op: OP_NONE, operand: win_data, acc: acc_r, hi: hi_r, lo: lo_r};
    unique case (state_r)
      S_EXT:   alu_req.op = OP_EXT;
      S_SUM:   alu_req.op = OP_ADD;
      S_SUBHI: begin
        alu_req.op      = OP_SUB;
        alu_req.operand = hi_r;
      end
      S_SUBLO: begin
        alu_req.op      = OP_SUB;
        alu_req.operand = lo_r;
      end
      default: alu_req.op = OP_NONE;
    endcase
  end

  tma_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // Sequence the two passes and the trim
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    acc_nxt   = alu_res.acc;
    hi_nxt    = alu_res.hi;
    lo_nxt    = alu_res.lo;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_EXT;
          idx_nxt   = '0;
          acc_nxt   = '0;
          hi_nxt    = '0;
          lo_nxt    = SAMPLE_MAX;
        end
      end
      S_EXT: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_LAST) begin
          state_nxt = S_SUM;
          idx_nxt   = '0;
        end
      end
      S_SUM: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_LAST) begin
          state_nxt = S_SUBHI;
          idx_nxt   = '0;
        end
      end
      S_SUBHI: state_nxt = S_SUBLO;
      S_SUBLO: state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result until the sink takes the transaction; divide by shifting
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = acc_r[SUM_W-1 -: SAMPLE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.filtered = out_data_r;

  // An accepted sample starts the extreme pass at the newest entry
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == S_EXT) && (idx_r == '0))
    else $error("extreme pass did not start after accepted sample");

  // Extremes are consistent once the first pass is over
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) |-> (hi_r >= lo_r))
    else $error("maximum below minimum after extreme pass");

  // The trimmed sum never goes negative before the extremes are removed
  a_trim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUBHI) |-> (acc_r >= SUM_W'(hi_r) + SUM_W'(lo_r)))
    else $error("sum smaller than the extremes it must drop");

  // A new result appears only from the load step
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result register loaded outside the load step");

endmodule
`default_nettype wire

@@ sim/tma_result_monitor.sv @@
// Result monitor: predicts the trimmed moving average and compares every result transaction.
module tma_result_monitor (
  input  logic clk,
  input  logic rst_n,
  tma_in_if    in_mon,
  tma_out_if   out_mon,
  output int   mismatch_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tma_pkg::*;

  // Window copy (entry 0 newest) and the results still owed by the block
  logic [SAMPLE_W-1:0] sample_window [WINDOW];
  logic [SAMPLE_W-1:0] expected_filtered [$];
  int                  fail_total = 0;

  // Shift the new sample in, then drop one max and one min from the window sum
  function automatic logic [SAMPLE_W-1:0] shift_and_predict(input logic [SAMPLE_W-1:0] s);
    int total;
    int hi;
    int lo;
    total = 0;
    hi    = 0;
    lo    = int'(SAMPLE_MAX);
    for (int i = WINDOW - 1; i > 0; i--) sample_window[i] = sample_window[i - 1];
    sample_window[0] = s;
    for (int i = 0; i < WINDOW; i++) begin
      total += int'(sample_window[i]);
      if (int'(sample_window[i]) > hi) hi = int'(sample_window[i]);
      if (int'(sample_window[i]) < lo) lo = int'(sample_window[i]);
    end
    total -= hi + lo;
    return SAMPLE_W'(total / WINDOW);
  endfunction

  // Record accepted samples, match accepted results against the oldest prediction
  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) sample_window[i] = '0;
      expected_filtered.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        expected_filtered.push_back(shift_and_predict(in_mon.sample));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_filtered.size() == 0) begin
          $error("filtered: unexpected result transaction, expected none, actual %0d",
                 out_mon.filtered);
          fail_total++;
        end else begin
          want = expected_filtered.pop_front();
          if (out_mon.filtered !== want) begin
            $error("filtered: expected %0d, actual %0d", want, out_mon.filtered);
            fail_total++;
          end
        end
      end
    end
    mismatch_count <= fail_total;
    pending        <= expected_filtered.size();
  end

endmodule

@@ sim/trimmed_moving_average_core_tb.sv @@
// Testbench top: clock, reset, sample stimulus, result back-pressure and the verdict.
module trimmed_moving_average_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tma_pkg::*;

  localparam int ITEM_COUNT   = 1550;
  localparam int BURST_LEN    = 150;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int REPEAT_RUN   = 16;

  localparam logic [SAMPLE_W-1:0] EDGE_SAMPLES [9] = '{
    SAMPLE_MAX, 12'd0, SAMPLE_MAX, SAMPLE_MAX, 12'd1,
    12'h800, 12'hAAA, 12'h555, 12'd4094
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tma_in_if  in_ch();
  tma_out_if out_ch();

  int mismatch_count;
  int pending;
  int idle_cycles = 0;
  int stall_left  = 0;
  bit tx_no_idle  = 1'b0;
  bit rx_no_idle  = 1'b0;

  logic [SAMPLE_W-1:0] cluster_base = '0;
  logic [SAMPLE_W-1:0] last_sample  = '0;

  trimmed_moving_average_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tma_result_monitor u_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  always #5ns clk = ~clk;

  // Mostly short idles, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Mix uniform values, extremes, tight clusters and repeats so ties occur often
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      v = $urandom_range(0, int'(SAMPLE_MAX));
    end else if (r < 55) begin
      case ($urandom_range(0, 3))
        0:       v = 0;
        1:       v = int'(SAMPLE_MAX);
        2:       v = 1;
        default: v = int'(SAMPLE_MAX) - 1;
      endcase
    end else if (r < 85) begin
      v = int'(cluster_base) + $urandom_range(0, 6) - 3;
      if (v < 0) v = 0;
      if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
    end else begin
      v = int'(last_sample);
    end
    last_sample = SAMPLE_W'(v);
    return SAMPLE_W'(v);
  endfunction

  // Offer one sample, hold it until accepted, then idle for the given gap
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input int gap);
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: random stalls on ready unless in a no-idle stretch
  always @(posedge clk) begin
    int n;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      n = rx_no_idle ? 0 : pick_gap();
      out_ch.ready <= (n == 0);
      stall_left   <= n;
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus: reset, directed edge cases, then random bursts
  initial begin
    int gap;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    rst_n        <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Start-up with reset zeros, extremes, repeated extremes, single-bit and alternating bit patterns
    foreach (EDGE_SAMPLES[i]) send_sample(EDGE_SAMPLES[i], pick_gap());
    // Fill the window with one value so the max equals the min
    for (int i = 0; i < REPEAT_RUN; i++) send_sample(12'h800, pick_gap());

    for (int i = 0; i < ITEM_COUNT; i++) begin
      // Pick the flavor of each burst: cluster center and idling on either side
      if (i % BURST_LEN == 0) begin
        cluster_base = SAMPLE_W'($urandom_range(0, int'(SAMPLE_MAX)));
        tx_no_idle   = ($urandom_range(0, 4) == 0);
        rx_no_idle   = ($urandom_range(0, 4) == 0);
      end
      gap = tx_no_idle ? 0 : pick_gap();
      send_sample(pick_sample(), gap);
      // Hold the sender until the block has drained every owed result
      if (i == ITEM_COUNT / 2 || i == (3 * ITEM_COUNT) / 4) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
    end
    in_ch.valid <= 1'b0;
    rx_no_idle  = 1'b0;

    // Drain the remaining results, then allow for any stray late result
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
